[src/terrain_grid_brush_engine_top_macros.svh]
// ----------------------------------------------------------------------------
// Terrain grid brush engine assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during rst.
// ----------------------------------------------------------------------------
`ifndef TERRAIN_GRID_BRUSH_ENGINE_TOP_MACROS_SVH
`define TERRAIN_GRID_BRUSH_ENGINE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TGBE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TGBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/tgbe_pkg.sv]
// ----------------------------------------------------------------------------
// Terrain grid brush engine package
// Beat types, command codes, sequencer states and the light clamp.
// ----------------------------------------------------------------------------
package tgbe_pkg;

  localparam logic [2:0] FUNC_ADD   = 3'd0;
  localparam logic [2:0] FUNC_SET   = 3'd1;
  localparam logic [2:0] FUNC_LIGHT = 3'd2;
  localparam logic [2:0] FUNC_WALL  = 3'd3;

  localparam logic [8:0] LIGHT_ONE = 9'd256;

  localparam int CMD_DEPTH = 2;
  localparam int PTR_W     = $clog2(CMD_DEPTH);

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SET,
    OP_LIGHT,
    OP_WALL,
    OP_READ
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL,
    ST_FETCH,
    ST_WALL,
    ST_SQUARE,
    ST_TEST,
    ST_ROOT,
    ST_SCALE,
    ST_DIVGO,
    ST_DIVIDE,
    ST_ACCUM,
    ST_NEXT,
    ST_CENTER,
    ST_CWAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]          func;
    logic [15:0]         pos_x;
    logic [15:0]         pos_y;
    logic signed [23:0]  height_value;
    logic [4:0]          radius;
    logic signed [11:0]  light_red;
    logic signed [11:0]  light_green;
    logic signed [11:0]  light_blue;
    logic                wall_set;
  } item_t;

  typedef struct packed {
    logic signed [31:0]  cell_height;
    logic [8:0]          cell_light_red;
    logic [8:0]          cell_light_green;
    logic [8:0]          cell_light_blue;
    logic [15:0]         cell_wall;
  } result_t;

  // Red sits in the low bits of a stored light word.
  typedef struct packed {
    logic [8:0] blue;
    logic [8:0] green;
    logic [8:0] red;
  } light_t;

  typedef struct packed {
    op_t                op;
    logic               stamp;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic signed [23:0] height;
    logic [4:0]         radius;
    light_t             light;
    logic               wall_set;
  } cmd_t;

  function automatic logic [8:0] clamp_light(input logic signed [11:0] v);
    logic [8:0] r;
    if (v < 0) begin
      r = 9'd0;
    end else if (v > $signed({3'b000, LIGHT_ONE})) begin
      r = LIGHT_ONE;
    end else begin
      r = v[8:0];
    end
    return r;
  endfunction

endpackage

[src/terrain_grid_brush_engine_top.sv]
// ----------------------------------------------------------------------------
// Terrain grid brush engine
// Radial falloff brush stamp over a wrapping square grid of cells.
// ----------------------------------------------------------------------------
// Command beats enter on push/full and each produces exactly one result beat
// on empty/pop describing the center cell after the command. The wall_type
// register is written on cfg_valid/cfg_ready; cfg_ready is always high, and
// the register should only change while no command is in flight.
// After reset the back end sweeps all three cell stores to zero, one cell
// per cycle, before the first command starts; there are 2^(2*GRID_BITS)
// cells (65536 at the default size). Commands queue up meanwhile.
// Per cell of the (2r+1) square, set height and set light write the cell,
// wall update reads and then writes it, and add height squares the distance
// and, inside the circle, takes the shared square root and runs the shared
// bit-serial divider, whose length is QW = 24 + clog2(MAX_RADIUS+1), before
// it writes the saturated sum; the center cell is read at the end.
// A two-entry command queue lets new beats arrive while a stamp runs, and
// the result register lets the next command start while the previous
// result waits; if pop stays low the back end holds in its final state.
// ----------------------------------------------------------------------------
module terrain_grid_brush_engine_top #(
  parameter int GRID_BITS  = 8,
  parameter int MAX_RADIUS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  tgbe_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output tgbe_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);

  logic           cmd_valid;
  logic           cmd_pop;
  tgbe_pkg::cmd_t cmd;

  // The register write never has to wait.
  assign cfg_ready = 1'b1;

  tgbe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  tgbe_back #(
    .GRID_BITS  (GRID_BITS),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .empty     (empty),
    .result    (result),
    .pop       (pop)
  );

endmodule

[src/tgbe_front.sv]
// ----------------------------------------------------------------------------
// Terrain grid brush engine front end
// Accepts command beats, decodes and clamps them, and queues them.
// ----------------------------------------------------------------------------
`include "terrain_grid_brush_engine_top_macros.svh"

module tgbe_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  tgbe_pkg::item_t item,
  output logic            cmd_valid,
  output tgbe_pkg::cmd_t  cmd,
  input  logic            cmd_pop
);

  tgbe_pkg::cmd_t                 fifo_mem [tgbe_pkg::CMD_DEPTH];
  logic [tgbe_pkg::PTR_W-1:0]     wr_ptr;
  logic [tgbe_pkg::PTR_W-1:0]     rd_ptr;
  logic [tgbe_pkg::PTR_W:0]       cnt;
  tgbe_pkg::cmd_t                 dec;
  logic                           acc;
  logic                           take;

  always_comb begin
    dec.pos_x    = item.pos_x;
    dec.pos_y    = item.pos_y;
    dec.height   = item.height_value;
    dec.radius   = item.radius;
    dec.wall_set = item.wall_set;
    dec.light.red   = tgbe_pkg::clamp_light(item.light_red);
    dec.light.green = tgbe_pkg::clamp_light(item.light_green);
    dec.light.blue  = tgbe_pkg::clamp_light(item.light_blue);
    case (item.func)
      tgbe_pkg::FUNC_ADD:   dec.op = tgbe_pkg::OP_ADD;
      tgbe_pkg::FUNC_SET:   dec.op = tgbe_pkg::OP_SET;
      tgbe_pkg::FUNC_LIGHT: dec.op = tgbe_pkg::OP_LIGHT;
      tgbe_pkg::FUNC_WALL:  dec.op = tgbe_pkg::OP_WALL;
      default:              dec.op = tgbe_pkg::OP_READ;
    endcase
    // An add with zero radius changes no cell, so it only reads the center.
    dec.stamp = (dec.op != tgbe_pkg::OP_READ) &&
                !(dec.op == tgbe_pkg::OP_ADD && item.radius == 5'd0);
  end

  assign full      = (cnt == (tgbe_pkg::PTR_W+1)'(tgbe_pkg::CMD_DEPTH));
  assign cmd_valid = (cnt != '0);
  assign cmd       = fifo_mem[rd_ptr];
  assign acc       = push && !full;
  assign take      = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (acc) begin
      fifo_mem[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (acc) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (acc && !take) begin
        cnt <= cnt + 1'b1;
      end else if (take && !acc) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  `TGBE_ASSERT_SAME(a_cnt_bound, 1'b1, cnt <= (tgbe_pkg::PTR_W+1)'(tgbe_pkg::CMD_DEPTH), "queue count above depth")
  `TGBE_ASSERT_NEXT(a_cnt_fill, acc && !take, cnt == $past(cnt) + 1'b1, "accepted beat not counted")

endmodule

[src/tgbe_isqrt.sv]
// ----------------------------------------------------------------------------
// Terrain grid brush engine square root
// Integer square root of a 32-bit value, one result bit per step, 16 steps.
// ----------------------------------------------------------------------------
module tgbe_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] value,
  output logic [15:0] root,
  output logic        done
);

  logic [31:0] rem;
  logic [31:0] res;
  logic [31:0] bitv;
  logic [3:0]  cnt;
  logic        busy;
  logic [31:0] trial;

  assign trial = res + bitv;
  assign root  = res[15:0];

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= value;
      res  <= '0;
      bitv <= 32'h4000_0000;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 4'd15;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[src/tgbe_div.sv]
// ----------------------------------------------------------------------------
// Terrain grid brush engine divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tgbe_div #(
  parameter int NW = 31,
  parameter int DW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [NW-1:0] quotient,
  output logic          done
);

  localparam int CW = $clog2(NW);

  logic [DW-1:0] den;
  logic [DW-1:0] rem;
  logic [DW:0]   shifted;
  logic          fits;
  logic [CW-1:0] cnt;
  logic          busy;

  assign shifted = {rem, quotient[NW-1]};
  assign fits    = (shifted >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      den      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      rem      <= fits ? DW'(shifted - {1'b0, den}) : shifted[DW-1:0];
      quotient <= {quotient[NW-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[src/tgbe_back.sv]
// ----------------------------------------------------------------------------
// Terrain grid brush engine back end
// Walks the brush square, runs read-modify-write on the cell stores and
// holds the result beat for the center cell.
// ----------------------------------------------------------------------------
`include "terrain_grid_brush_engine_top_macros.svh"

module tgbe_back #(
  parameter int GRID_BITS  = 8,
  parameter int MAX_RADIUS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  input  tgbe_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  input  logic              cfg_valid,
  input  logic [15:0]       cfg_data,
  output logic              empty,
  output tgbe_pkg::result_t result,
  input  logic              pop
);

  localparam int IW    = 2 * GRID_BITS;
  localparam int CELLS = 1 << IW;
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int KW    = RW + 1;
  localparam int DXW   = KW + 9;
  localparam int PW    = 24 + RW + 8;
  localparam int QW    = 24 + RW;

  tgbe_pkg::state_t   state;
  tgbe_pkg::state_t   state_next;

  logic signed [31:0] height_mem [CELLS];
  tgbe_pkg::light_t   light_mem  [CELLS];
  logic [15:0]        wall_mem   [CELLS];
  logic signed [31:0] rd_h;
  tgbe_pkg::light_t   rd_l;
  logic [15:0]        rd_w;

  tgbe_pkg::op_t      op;
  logic [15:0]        pos_x;
  logic [15:0]        pos_y;
  logic signed [23:0] height;
  tgbe_pkg::light_t   light;
  logic               wall_set;
  logic [RW-1:0]      r;
  logic               neg;
  logic [23:0]        mag;
  logic [31:0]        big_r2;
  logic [15:0]        wall_type;

  logic [KW-1:0]      kx;
  logic [KW-1:0]      ky;
  logic [IW-1:0]      addr;
  logic [IW-1:0]      clr_addr;
  logic signed [DXW-1:0] dx;
  logic signed [DXW-1:0] dy;
  logic [31:0]        d2;
  logic [PW-1:0]      prod;
  logic               res_valid;

  logic [RW-1:0]      r_c;
  logic [KW-1:0]      span;
  logic               last;
  logic               clr_last;
  logic [15:0]        sx;
  logic [15:0]        sy;
  logic [15:0]        cx;
  logic [15:0]        cy;
  logic [IW-1:0]      idx_c;
  logic [IW-1:0]      center_c;
  logic signed [KW:0] offx;
  logic signed [KW:0] offy;
  logic signed [DXW-1:0] dx_c;
  logic signed [DXW-1:0] dy_c;
  logic signed [2*DXW-1:0] sqx;
  logic signed [2*DXW-1:0] sqy;
  logic [RW+7:0]      diff_c;
  logic signed [32:0] sum_c;
  logic signed [31:0] sat_c;
  logic [15:0]        wall_c;

  logic               sq_start;
  logic               sq_done;
  logic [15:0]        root;
  logic               div_start;
  logic               div_done;
  logic [QW-1:0]      quot;

  logic               we_h;
  logic               we_l;
  logic               we_w;
  logic [IW-1:0]      wr_addr;
  logic signed [31:0] wd_h;
  tgbe_pkg::light_t   wd_l;
  logic [15:0]        wd_w;

  tgbe_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (d2),
    .root  (root),
    .done  (sq_done)
  );

  tgbe_div #(
    .NW (QW),
    .DW (RW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod[PW-1:8]),
    .divisor  (r),
    .quotient (quot),
    .done     (div_done)
  );

  // Cell address, offsets and the add and wall write data for the position.
  always_comb begin
    r_c  = (32'(cmd.radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(cmd.radius);
    span = {r, 1'b0};
    last = (kx == span) && (ky == span);
    clr_last = (clr_addr == '1);
    sx   = 16'(pos_x[15:8]) - 16'(r) + 16'(kx);
    sy   = 16'(pos_y[15:8]) - 16'(r) + 16'(ky);
    cx   = 16'(pos_x[15:8]);
    cy   = 16'(pos_y[15:8]);
    idx_c    = {sy[GRID_BITS-1:0], sx[GRID_BITS-1:0]};
    center_c = {cy[GRID_BITS-1:0], cx[GRID_BITS-1:0]};
    offx = $signed({2'b00, r}) - $signed({1'b0, kx});
    offy = $signed({2'b00, r}) - $signed({1'b0, ky});
    dx_c = $signed({offx, 8'h00} + {{(KW+1){1'b0}}, pos_x[7:0]});
    dy_c = $signed({offy, 8'h00} + {{(KW+1){1'b0}}, pos_y[7:0]});
    sqx  = dx * dx;
    sqy  = dy * dy;
    diff_c = (RW+8)'(32'({r, 8'h00}) - 32'(root));
    sum_c  = $signed({rd_h[31], rd_h}) +
             (neg ? -$signed(33'(quot)) : $signed(33'(quot)));
    if (sum_c[32] != sum_c[31]) begin
      sat_c = sum_c[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_c = sum_c[31:0];
    end
    if (wall_type == 16'd0) begin
      wall_c = 16'd0;
    end else if (wall_set) begin
      wall_c = rd_w | wall_type;
    end else begin
      wall_c = rd_w & ~wall_type;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tgbe_pkg::ST_CLEAR:  if (clr_last) state_next = tgbe_pkg::ST_IDLE;
      tgbe_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          state_next = cmd.stamp ? tgbe_pkg::ST_CELL : tgbe_pkg::ST_CENTER;
        end
      end
      tgbe_pkg::ST_CELL: begin
        case (op)
          tgbe_pkg::OP_ADD:  state_next = tgbe_pkg::ST_SQUARE;
          tgbe_pkg::OP_WALL: state_next = tgbe_pkg::ST_FETCH;
          default:           state_next = tgbe_pkg::ST_NEXT;
        endcase
      end
      tgbe_pkg::ST_FETCH:  state_next = tgbe_pkg::ST_WALL;
      tgbe_pkg::ST_WALL:   state_next = tgbe_pkg::ST_NEXT;
      tgbe_pkg::ST_SQUARE: state_next = tgbe_pkg::ST_TEST;
      tgbe_pkg::ST_TEST: begin
        state_next = (d2 < big_r2) ? tgbe_pkg::ST_ROOT : tgbe_pkg::ST_NEXT;
      end
      tgbe_pkg::ST_ROOT:   if (sq_done) state_next = tgbe_pkg::ST_SCALE;
      tgbe_pkg::ST_SCALE:  state_next = tgbe_pkg::ST_DIVGO;
      tgbe_pkg::ST_DIVGO:  state_next = tgbe_pkg::ST_DIVIDE;
      tgbe_pkg::ST_DIVIDE: if (div_done) state_next = tgbe_pkg::ST_ACCUM;
      tgbe_pkg::ST_ACCUM:  state_next = tgbe_pkg::ST_NEXT;
      tgbe_pkg::ST_NEXT: begin
        state_next = last ? tgbe_pkg::ST_CENTER : tgbe_pkg::ST_CELL;
      end
      tgbe_pkg::ST_CENTER: state_next = tgbe_pkg::ST_CWAIT;
      tgbe_pkg::ST_CWAIT:  state_next = tgbe_pkg::ST_DONE;
      tgbe_pkg::ST_DONE:   if (!res_valid) state_next = tgbe_pkg::ST_IDLE;
      default:             state_next = tgbe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop   = 1'b0;
    sq_start  = 1'b0;
    div_start = 1'b0;
    we_h      = 1'b0;
    we_l      = 1'b0;
    we_w      = 1'b0;
    wr_addr   = addr;
    wd_h      = sat_c;
    wd_l      = light;
    wd_w      = wall_c;
    case (state)
      tgbe_pkg::ST_CLEAR: begin
        wr_addr = clr_addr;
        wd_h    = '0;
        wd_l    = '0;
        wd_w    = '0;
        we_h    = 1'b1;
        we_l    = 1'b1;
        we_w    = 1'b1;
      end
      tgbe_pkg::ST_IDLE:  cmd_pop = cmd_valid;
      tgbe_pkg::ST_CELL: begin
        wr_addr = idx_c;
        wd_h    = 32'(height);
        we_h    = (op == tgbe_pkg::OP_SET);
        we_l    = (op == tgbe_pkg::OP_LIGHT);
      end
      tgbe_pkg::ST_WALL:  we_w = 1'b1;
      tgbe_pkg::ST_TEST:  sq_start = (d2 < big_r2);
      tgbe_pkg::ST_DIVGO: div_start = 1'b1;
      tgbe_pkg::ST_ACCUM: we_h = 1'b1;
      default: begin
      end
    endcase
  end

  // Stores: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (we_h) begin
      height_mem[wr_addr] <= wd_h;
    end
    if (we_l) begin
      light_mem[wr_addr] <= wd_l;
    end
    if (we_w) begin
      wall_mem[wr_addr] <= wd_w;
    end
    rd_h <= height_mem[addr];
    rd_l <= light_mem[addr];
    rd_w <= wall_mem[addr];
  end

  always_ff @(posedge clk) begin
    case (state)
      tgbe_pkg::ST_IDLE: begin
        op       <= cmd.op;
        pos_x    <= cmd.pos_x;
        pos_y    <= cmd.pos_y;
        height   <= cmd.height;
        light    <= cmd.light;
        wall_set <= cmd.wall_set;
        r        <= r_c;
        neg      <= cmd.height[23];
        mag      <= cmd.height[23] ? 24'(-cmd.height) : 24'(cmd.height);
        big_r2   <= {16'(r_c * r_c), 16'h0000};
      end
      tgbe_pkg::ST_CELL: begin
        addr <= idx_c;
        dx   <= dx_c;
        dy   <= dy_c;
      end
      tgbe_pkg::ST_SQUARE: d2   <= 32'($unsigned(sqx)) + 32'($unsigned(sqy));
      tgbe_pkg::ST_SCALE:  prod <= mag * diff_c;
      tgbe_pkg::ST_CENTER: addr <= center_c;
      tgbe_pkg::ST_DONE: begin
        if (!res_valid) begin
          result.cell_height      <= rd_h;
          result.cell_light_red   <= rd_l.red;
          result.cell_light_green <= rd_l.green;
          result.cell_light_blue  <= rd_l.blue;
          result.cell_wall        <= rd_w;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tgbe_pkg::ST_CLEAR;
      clr_addr  <= '0;
      kx        <= '0;
      ky        <= '0;
      res_valid <= 1'b0;
      wall_type <= '0;
    end else begin
      state <= state_next;
      if (state == tgbe_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cfg_valid) begin
        wall_type <= cfg_data;
      end
      if (state == tgbe_pkg::ST_IDLE) begin
        kx <= '0;
        ky <= '0;
      end else if (state == tgbe_pkg::ST_NEXT) begin
        if (kx == span) begin
          kx <= '0;
          ky <= ky + 1'b1;
        end else begin
          kx <= kx + 1'b1;
        end
      end
      if (state == tgbe_pkg::ST_DONE && !res_valid) begin
        res_valid <= 1'b1;
      end else if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign empty = !res_valid;

  `TGBE_ASSERT_SAME(a_pop_idle, cmd_pop, state == tgbe_pkg::ST_IDLE, "command taken while busy")
  `TGBE_ASSERT_SAME(a_root_inside, state == tgbe_pkg::ST_SCALE, 32'(root) < 32'({r, 8'h00}), "falloff root outside radius")
  `TGBE_ASSERT_NEXT(a_clear_runs, state == tgbe_pkg::ST_CLEAR && !clr_last, state == tgbe_pkg::ST_CLEAR, "clearing pass cut short")

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// Brush engine testbench
// Drives brush commands through the command queue, models every stamp on a
// private copy of the height, light and wall stores, and compares each
// result beat against the predicted state of the command's center cell.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID   = 8;
  localparam int RAD_MAX = 16;
  localparam int CELLS  = 1 << (2 * GRID);
  // Function codes past the defined ones behave as plain reads.
  localparam logic [2:0] FUNC_SPARE_A = 3'd5;
  localparam logic [2:0] FUNC_SPARE_B = 3'd6;
  localparam logic [2:0] FUNC_SPARE_C = 3'd7;
  localparam logic [15:0] WALL_NONE = 16'h0000;
  localparam logic [15:0] WALL_ALL  = 16'hFFFF;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  tgbe_pkg::item_t   item = '0;
  logic              empty;
  logic              pop = 1'b0;
  tgbe_pkg::result_t result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [15:0]       cfg_data = '0;

  always #10 clk = ~clk;

  terrain_grid_brush_engine_top i_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Private copy of the grid state, updated when a command beat is accepted.
  int                height_cells[CELLS];
  tgbe_pkg::light_t  light_cells[CELLS];
  logic [15:0]       wall_cells[CELLS];
  logic [15:0]       wall_mask = '0;

  tgbe_pkg::result_t center_q[$];
  int          errors = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          hold_left = 0;

  function automatic longint root_floor(longint v);
    longint lo, hi, mid;
    lo = 0;
    hi = 65536;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic logic [8:0] light_level(logic signed [11:0] v);
    if (v < 0) return 9'd0;
    if (v > 256) return 9'd256;
    return v[8:0];
  endfunction

  // Applies one command to the private grid and returns the center cell.
  function automatic tgbe_pkg::result_t stamp_brush(tgbe_pkg::item_t it);
    tgbe_pkg::result_t res;
    int      r, xi, yi, sx, sy, idx, c;
    longint  dx, dy, d, big_r, mag, delta, sum, h;
    tgbe_pkg::light_t lt;
    r  = (it.radius > RAD_MAX) ? RAD_MAX : int'(it.radius);
    xi = int'(it.pos_x >> 8);
    yi = int'(it.pos_y >> 8);
    h  = longint'(it.height_value);
    lt.red   = light_level(it.light_red);
    lt.green = light_level(it.light_green);
    lt.blue  = light_level(it.light_blue);
    if (it.func <= tgbe_pkg::OP_WALL && !(it.func == tgbe_pkg::OP_ADD && r == 0)) begin
      for (int ky = 0; ky <= 2 * r; ky++) begin
        sy = yi - r + ky;
        for (int kx = 0; kx <= 2 * r; kx++) begin
          sx  = xi - r + kx;
          idx = ((sy & 255) << GRID) | (sx & 255);
          case (it.func)
            tgbe_pkg::OP_ADD: begin
              dx = longint'(it.pos_x) - sx * 256;
              dy = longint'(it.pos_y) - sy * 256;
              d = root_floor(dx * dx + dy * dy);
              big_r = r * 256;
              if (d < big_r) begin
                mag = (h < 0) ? -h : h;
                delta = (mag * (big_r - d)) / big_r;
                sum = longint'(height_cells[idx]) + ((h < 0) ? -delta : delta);
                if (sum > 64'sd2147483647) sum = 64'sd2147483647;
                if (sum < -64'sd2147483648) sum = -64'sd2147483648;
                height_cells[idx] = int'(sum);
              end
            end
            tgbe_pkg::OP_SET:   height_cells[idx] = int'(h);
            tgbe_pkg::OP_LIGHT: light_cells[idx] = lt;
            default: begin
              if (wall_mask == WALL_NONE) wall_cells[idx] = WALL_NONE;
              else if (it.wall_set) wall_cells[idx] = wall_cells[idx] | wall_mask;
              else wall_cells[idx] = wall_cells[idx] & ~wall_mask;
            end
          endcase
        end
      end
    end
    c = ((yi & 255) << GRID) | (xi & 255);
    res.cell_height      = height_cells[c];
    res.cell_light_red   = light_cells[c].red;
    res.cell_light_green = light_cells[c].green;
    res.cell_light_blue  = light_cells[c].blue;
    res.cell_wall        = wall_cells[c];
    return res;
  endfunction

  function automatic tgbe_pkg::item_t brush(logic [2:0] f, logic [15:0] px,
                                            logic [15:0] py,
                                            logic signed [23:0] h, logic [4:0] r);
    tgbe_pkg::item_t it;
    it = '0;
    it.func = f;
    it.pos_x = px;
    it.pos_y = py;
    it.height_value = h;
    it.radius = r;
    return it;
  endfunction

  // Offers one command beat, then idles at random per the sender setting.
  // Full is sampled at the falling edge, where it is stable for the coming
  // rising edge, so acceptance never depends on event order.
  task automatic send_cmd(tgbe_pkg::item_t it);
    item <= it;
    push <= 1'b1;
    forever begin
      @(negedge clk);
      if (!full) break;
      @(posedge clk);
    end
    @(posedge clk);
    center_q.push_back(stamp_brush(it));
    items_sent++;
    if ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic end_burst();
    push <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every result has come back; each command yields exactly one
  // result, so a short pad is enough before the block is known to be idle.
  task automatic drain();
    end_burst();
    while (center_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_wall_type(logic [15:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
      @(posedge clk);
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
    wall_mask = v;
  endtask

  // Result side: the checker looks at the beat at the falling edge, the
  // next rising edge takes it, and pop is redrawn at each rising edge outside hold-off.
  always @(negedge clk) begin
    if (!rst && pop && !empty) begin
      results_seen++;
      if (center_q.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, result);
        errors++;
      end else begin
        tgbe_pkg::result_t want;
        want = center_q.pop_front();
        if (result.cell_height !== want.cell_height) begin
          $display("%0t: cell_height expected %0d actual %0d", $time,
                   want.cell_height, result.cell_height);
          errors++;
        end
        if (result.cell_light_red !== want.cell_light_red) begin
          $display("%0t: cell_light_red expected %0d actual %0d", $time,
                   want.cell_light_red, result.cell_light_red);
          errors++;
        end
        if (result.cell_light_green !== want.cell_light_green) begin
          $display("%0t: cell_light_green expected %0d actual %0d", $time,
                   want.cell_light_green, result.cell_light_green);
          errors++;
        end
        if (result.cell_light_blue !== want.cell_light_blue) begin
          $display("%0t: cell_light_blue expected %0d actual %0d", $time,
                   want.cell_light_blue, result.cell_light_blue);
          errors++;
        end
        if (result.cell_wall !== want.cell_wall) begin
          $display("%0t: cell_wall expected %h actual %h", $time,
                   want.cell_wall, result.cell_wall);
          errors++;
        end
      end
    end
  end

  // Pop is held low for the whole hold-off stretch, counted down here.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Fixed commands: the extremes, every function, wrap and clamp cases.
  task automatic test_directed();
    tgbe_pkg::item_t it;
    send_cmd(brush(tgbe_pkg::OP_READ, 16'h0000, 16'h0000, 24'sd0, 5'd0));
    send_cmd(brush(tgbe_pkg::OP_SET, 16'h0080, 16'h00FF, 24'sh7FFFFF, 5'd1));
    // A full-scale add lands on a cell set to the same full-scale height.
    send_cmd(brush(tgbe_pkg::OP_ADD, 16'h0080, 16'h00FF, 24'sh7FFFFF, 5'd4));
    send_cmd(brush(tgbe_pkg::OP_SET, 16'h0380, 16'h0340, -24'sh800000, 5'd0));
    send_cmd(brush(tgbe_pkg::OP_ADD, 16'h0380, 16'h0340, -24'sh800000, 5'd2));
    // A zero radius adds nothing.
    send_cmd(brush(tgbe_pkg::OP_ADD, 16'h0380, 16'h0340, 24'sh123456, 5'd0));
    // Full radius at the grid corner wraps on both axes.
    send_cmd(brush(tgbe_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 24'sh400000, 5'd16));
    send_cmd(brush(tgbe_pkg::OP_READ, 16'h0000, 16'h0000, 24'sd0, 5'd0));
    // A radius past the maximum is cut to the maximum.
    send_cmd(brush(tgbe_pkg::OP_SET, 16'h0A00, 16'hF000, 24'sh000100, 5'd31));
    it = brush(tgbe_pkg::OP_LIGHT, 16'h0101, 16'h0202, 24'sd0, 5'd2);
    it.light_red = -12'sd1024; it.light_green = 12'sd1024; it.light_blue = 12'sd256;
    send_cmd(it);
    it.light_red = 12'sd257; it.light_green = -12'sd1; it.light_blue = 12'sd0;
    it.radius = 5'd0;
    send_cmd(it);
    it = brush(tgbe_pkg::OP_WALL, 16'h0101, 16'h0202, 24'sd0, 5'd1);
    it.wall_set = 1'b1;
    send_cmd(it);
    it.func = FUNC_SPARE_A; send_cmd(it);
    it.func = FUNC_SPARE_B; send_cmd(it);
    it.func = FUNC_SPARE_C; send_cmd(it);
    drain();
  endtask

  // Wall mode under the register extremes, a fixed mask and one random mask.
  task automatic test_wall_type();
    tgbe_pkg::item_t it;
    logic [15:0] masks[4];
    masks[0] = WALL_ALL;
    masks[1] = 16'h00F0;
    masks[2] = WALL_NONE;
    masks[3] = 16'(($urandom_range(1, 65535)));
    foreach (masks[m]) begin
      write_wall_type(masks[m]);
      it = brush(tgbe_pkg::OP_WALL, 16'h0505, 16'h0606, 24'sd0, 5'd1);
      it.wall_set = 1'b1;
      send_cmd(it);
      it.wall_set = 1'b0; it.radius = 5'd0;
      send_cmd(it);
      it.wall_set = 1'b1; it.radius = 5'd3;
      send_cmd(it);
      drain();
    end
  endtask

  function automatic tgbe_pkg::item_t random_brush();
    tgbe_pkg::item_t it;
    int    pick;
    it.func = 3'($urandom_range(0, 7));
    if (it.func > tgbe_pkg::OP_READ && $urandom_range(3) != 0) it.func = tgbe_pkg::OP_READ;
    // Centers stay near the origin so later commands revisit stamped cells,
    // and the region straddles the wrap.
    it.pos_x = {8'($urandom_range(0, 5) - 2), 8'($urandom)};
    it.pos_y = {8'($urandom_range(0, 5) - 2), 8'($urandom)};
    if ($urandom_range(9) == 0) it.pos_x = 16'($urandom);
    if ($urandom_range(9) == 0) it.pos_y = 16'($urandom);
    it.height_value = 24'($urandom);
    if ($urandom_range(3) == 0) it.height_value = 24'($signed($urandom_range(0, 2047)) - 1024);
    pick = $urandom_range(99);
    if (pick < 85) it.radius = 5'($urandom_range(0, 3));
    else if (it.func == tgbe_pkg::OP_ADD && pick < 98) it.radius = 5'($urandom_range(4, 6));
    else it.radius = 5'($urandom_range(0, 31));
    it.light_red   = 12'($signed($urandom_range(0, 2048)) - 1024);
    it.light_green = 12'($signed($urandom_range(0, 2048)) - 1024);
    it.light_blue  = 12'($signed($urandom_range(0, 2048)) - 1024);
    it.wall_set = 1'($urandom);
    return it;
  endfunction

  // Three phases with different idle patterns and a new wall mask each.
  task automatic test_random();
    int tx[3];
    int rx[3];
    tx[0] = 15; rx[0] = 70;
    tx[1] = 70; rx[1] = 15;
    tx[2] = 0;  rx[2] = 0;
    for (int p = 0; p < 3; p++) begin
      write_wall_type(16'($urandom));
      tx_idle_pct = tx[p];
      rx_idle_pct = rx[p];
      repeat (150) send_cmd(random_brush());
      drain();
    end
  endtask

  // The receiver stops for a long stretch while commands keep coming, so the
  // queue and result register fill and full holds the sender back.
  task automatic test_backpressure();
    tgbe_pkg::item_t it;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_left = 3000;
    for (int k = 0; k < 12; k++) begin
      it = random_brush();
      it.radius = 5'($urandom_range(0, 1));
      send_cmd(it);
    end
    drain();
  endtask

  initial begin
    // The block clears its stores after reset, so the model starts at zero.
    foreach (light_cells[i]) begin
      light_cells[i] = '0;
      wall_cells[i]  = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_wall_type();
    test_random();
    test_backpressure();
    $display("Covered %0d command beats and %0d result beats over every function,",
             items_sent, results_seen);
    $display("four wall masks, three idle patterns and one long result stall.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // The bound lies far beyond any correct run, the clear sweep of all 65536
  // cells after reset included.
  initial begin
    #200ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
